FILE: design/bis_pkg.sv
// Shared types and constants for the binary insertion sorter.
package bis_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 8;

    // One held record as it sits in the store.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [DATA_W-1:0]       data;
    } t_rec;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT,
        S_INS,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    // Port strobes of the store memory.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    // One sorted word handed to the output register.
    typedef struct packed {
        logic valid;
        t_rec rec;
        logic last;
    } t_emit;

endpackage

FILE: design/binary_insertion_sorter_unit.sv
// Top level of the binary insertion sorter: store, sequencer and output register.
//
// Each input word (signed key, data byte, last flag) is taken only while the
// sequencer is idle. Insertion accepts the word, then runs a binary search
// in which each probe is one memory read and one compare (up to 6 probes at
// DEPTH 64) followed by a closing step, then moves each held record above
// the insert place up by one, again with a closing step, and writes the new
// record; the single read port of the store sets this order of steps. A word
// marked last then reads out the whole store in ascending order, reading each
// record and then loading it into the output register, waiting while the
// output stalls, and the store is empty afterwards. Equal keys keep the
// newest first. Words that arrive with DEPTH records held are dropped; a
// last word arriving then still triggers the read-out. o_out_overflow is
// always 0. The store needs no clearing after reset.
module binary_insertion_sorter_unit #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [bis_pkg::KEY_W-1:0]  i_in_key,
    input  logic [bis_pkg::DATA_W-1:0]        i_in_data,
    input  logic                              i_in_last,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [bis_pkg::KEY_W-1:0]  o_out_key,
    output logic [bis_pkg::DATA_W-1:0]        o_out_data,
    output logic                              o_out_last,
    output logic                              o_out_overflow
);
    import bis_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_mem_ctl      mem_ctl;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    t_rec          mem_wdata;
    t_rec          mem_rdata;
    t_emit         emit;
    logic          load_ok;

    logic          r_out_valid;
    t_rec          r_out_rec;
    logic          r_out_last;

    bis_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bis_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_key   (i_in_key),
        .i_in_data  (i_in_data),
        .i_in_last  (i_in_last),
        .o_in_stall (o_in_stall),
        .i_load_ok  (load_ok),
        .o_emit     (emit),
        .o_mem_ctl  (mem_ctl),
        .o_waddr    (mem_waddr),
        .o_wdata    (mem_wdata),
        .o_raddr    (mem_raddr),
        .i_rdata    (mem_rdata)
    );

    // The output register can take a word when empty or being drained.
    assign load_ok = !r_out_valid || !i_out_stall;

    // Output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_out_rec  <= emit.rec;
            r_out_last <= emit.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_key      = r_out_rec.key;
    assign o_out_data     = r_out_rec.data;
    assign o_out_last     = r_out_last;
    assign o_out_overflow = 1'b0;

endmodule

FILE: design/bis_mem.sv
// Record store: one write port and one read port with registered read data.
module bis_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  bis_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_waddr,
    input  bis_pkg::t_rec     i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output bis_pkg::t_rec     o_rdata
);
    import bis_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/bis_ctrl.sv
// Sequencer: binary search, shift-up, insert and ordered read-out over the store.
module bis_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic signed [bis_pkg::KEY_W-1:0]      i_in_key,
    input  logic [bis_pkg::DATA_W-1:0]            i_in_data,
    input  logic                                  i_in_last,
    output logic                                  o_in_stall,
    input  logic                                  i_load_ok,
    output bis_pkg::t_emit                        o_emit,
    output bis_pkg::t_mem_ctl                     o_mem_ctl,
    output logic [AW-1:0]                         o_waddr,
    output bis_pkg::t_rec                         o_wdata,
    output logic [AW-1:0]                         o_raddr,
    input  bis_pkg::t_rec                         i_rdata
);
    import bis_pkg::*;

    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_state                  r_state, n_state;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [DATA_W-1:0]       r_data, n_data;
    logic                    r_last, n_last;
    logic [CW-1:0]           r_held, n_held;
    logic                    r_dropped, n_dropped;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hi, n_hi;
    logic [AW-1:0]           r_mid, n_mid;
    logic [CW-1:0]           r_j, n_j;
    logic                    r_wpend, n_wpend;
    logic [CW-1:0]           r_k, n_k;
    logic [CW:0]             mid_sum;

    // Midpoint of the open search window.
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_held    <= '0;
            r_dropped <= 1'b0;
            r_wpend   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_held    <= n_held;
            r_dropped <= n_dropped;
            r_wpend   <= n_wpend;
        end
    end

    // Working registers of the current word.
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_data <= n_data;
        r_last <= n_last;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_j    <= n_j;
        r_k    <= n_k;
    end

    // Next state and memory strobes.
    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_data    = r_data;
        n_last    = r_last;
        n_held    = r_held;
        n_dropped = r_dropped;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_j       = r_j;
        n_wpend   = r_wpend;
        n_k       = r_k;
        o_mem_ctl = '0;
        o_waddr   = '0;
        o_wdata   = '{key: r_key, data: r_data};
        o_raddr   = '0;
        o_emit    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key  = i_in_key;
                    n_data = i_in_data;
                    n_last = i_in_last;
                    n_lo   = '0;
                    n_hi   = r_held;
                    n_k    = '0;
                    if (r_held == FULL) begin
                        // Store full: the word is dropped, a last word still flushes.
                        n_dropped = 1'b1;
                        n_state   = i_in_last ? S_EMIT_RD : S_IDLE;
                    end else begin
                        n_state = S_SRCH_RD;
                    end
                end
            end
            S_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    o_mem_ctl.re = 1'b1;
                    o_raddr      = AW'(mid_sum[CW:1]);
                    n_mid        = AW'(mid_sum[CW:1]);
                    n_state      = S_SRCH_CMP;
                end else begin
                    n_j     = r_held;
                    n_wpend = 1'b0;
                    n_state = S_SHIFT;
                end
            end
            S_SRCH_CMP: begin
                // Move right only on a strictly greater key, so the new word goes before equal keys.
                if (r_key > $signed(i_rdata.key)) begin
                    n_lo = CW'(r_mid) + CW'(1);
                end else begin
                    n_hi = CW'(r_mid);
                end
                n_state = S_SRCH_RD;
            end
            S_SHIFT: begin
                // Write the entry read last cycle one place up, read the next lower one.
                if (r_wpend) begin
                    o_mem_ctl.we = 1'b1;
                    o_waddr      = AW'(r_j + CW'(1));
                    o_wdata      = i_rdata;
                end
                if (r_j > r_lo) begin
                    o_mem_ctl.re = 1'b1;
                    o_raddr      = AW'(r_j - CW'(1));
                    n_j          = r_j - CW'(1);
                    n_wpend      = 1'b1;
                end else begin
                    n_wpend = 1'b0;
                    n_state = S_INS;
                end
            end
            S_INS: begin
                o_mem_ctl.we = 1'b1;
                o_waddr      = AW'(r_lo);
                n_held       = r_held + CW'(1);
                n_k          = '0;
                n_state      = r_last ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
                o_mem_ctl.re = 1'b1;
                o_raddr      = AW'(r_k);
                n_state      = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (i_load_ok) begin
                    o_emit.valid = 1'b1;
                    o_emit.rec   = i_rdata;
                    o_emit.last  = (r_k + CW'(1)) == r_held;
                    if ((r_k + CW'(1)) == r_held) begin
                        n_held  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // The fill count never passes the capacity.
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= FULL)
        else $error("held count beyond capacity");

    // The store is never written during read-out.
    a_no_write_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_RD || r_state == S_EMIT_LD) |-> !o_mem_ctl.we)
        else $error("store written during read-out");

    // The shift pointer never passes below the insert place.
    a_shift_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_lo <= r_j))
        else $error("shift pointer below insert place");

    // The final sorted word empties the store.
    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.valid && o_emit.last) |=> (r_held == '0 && r_state == S_IDLE))
        else $error("store not emptied after the final word");

    // The drop flag is sticky until reset.
    a_drop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropped |=> r_dropped)
        else $error("drop flag cleared");

endmodule
